>>> sv/z80id_pkg.sv
// ----------------------------------------------------------------------------
// Z80 instruction decoder package
// Shared constants, types and decode functions for the Z80 instruction decoder.
// ----------------------------------------------------------------------------
package z80id_pkg;

  localparam int PC_W = 16;
  localparam int MN_W = 7;
  localparam int MODE_W = 5;

  localparam logic [7:0] OP_CB = 8'hcb;
  localparam logic [7:0] OP_DD = 8'hdd;
  localparam logic [7:0] OP_ED = 8'hed;
  localparam logic [7:0] OP_FD = 8'hfd;

  localparam logic [4:0] MD_IMPL = 5'd0, MD_IMM8 = 5'd1, MD_IMM16 = 5'd2,
    MD_ABS8 = 5'd3, MD_ABS16 = 5'd4, MD_REL = 5'd5, MD_A = 5'd6, MD_HL = 5'd7,
    MD_SP = 5'd8, MD_RLO = 5'd9, MD_RLOX = 5'd10, MD_RMID = 5'd11,
    MD_RMIDX = 5'd12, MD_PAIR = 5'd13, MD_PAIRAF = 5'd14, MD_CC = 5'd15,
    MD_CC2 = 5'd16, MD_BITN = 5'd17, MD_BITR = 5'd18, MD_RSTV = 5'd19,
    MD_BCI = 5'd20, MD_DEI = 5'd21, MD_HLI = 5'd22, MD_XYD = 5'd23,
    MD_SPI = 5'd24, MD_DEHL = 5'd25, MD_AFAF = 5'd26, MD_PORTC = 5'd27,
    MD_IREG = 5'd28, MD_RREG = 5'd29, MD_ZERO = 5'd30;

  localparam logic [6:0] MN_ADC = 7'd0, MN_ADD = 7'd1, MN_BIT = 7'd3,
    MN_CALL = 7'd4, MN_DEC = 7'd13, MN_DI = 7'd14, MN_DJNZ = 7'd15,
    MN_EI = 7'd16, MN_EX = 7'd17, MN_EXX = 7'd18, MN_HALT = 7'd19,
    MN_IM0 = 7'd20, MN_IM1 = 7'd21, MN_IM2 = 7'd22, MN_IN = 7'd23,
    MN_INC = 7'd24, MN_JP = 7'd29, MN_JR = 7'd30, MN_LD = 7'd31,
    MN_NEG = 7'd36, MN_NOP = 7'd37, MN_OUT = 7'd41, MN_POP = 7'd44,
    MN_PUSH = 7'd45, MN_RES = 7'd46, MN_RET = 7'd47, MN_RETI = 7'd48,
    MN_RETN = 7'd49, MN_RLD = 7'd54, MN_RRD = 7'd59, MN_RST = 7'd60,
    MN_SBC = 7'd61, MN_SET = 7'd63, MN_ILLEGAL = 7'd70;

  typedef enum logic [1:0] {
    SPACE_MAIN = 2'd0,
    SPACE_CB = 2'd1,
    SPACE_ED = 2'd2
  } space_t;

  typedef struct packed {
    logic [MN_W-1:0]   mn;
    logic [MODE_W-1:0] dm;
    logic [MODE_W-1:0] sm;
  } decoded_t;

  // Prefix stage result, handed to the table stage.
  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic [7:0]      b0, b1, b2, b3;
    logic [7:0]      op;
    logic [1:0]      sel;
    space_t          space;
  } pfx_t;

  // Table stage result, handed to the operand stage.
  typedef struct packed {
    pfx_t     p;
    decoded_t d;
  } tbl_t;

  function automatic decoded_t mk(input logic [6:0] mn, input logic [4:0] dm,
                                  input logic [4:0] sm);
    decoded_t d;
    d.mn = mn; d.dm = dm; d.sm = sm;
    return d;
  endfunction

  function automatic logic [6:0] alu_mn(input logic [2:0] y);
    logic [6:0] r;
    case (y)
      3'd0: r = 7'd1;
      3'd1: r = 7'd0;
      3'd2: r = 7'd68;
      3'd3: r = 7'd61;
      3'd4: r = 7'd2;
      3'd5: r = 7'd69;
      3'd6: r = 7'd38;
      default: r = 7'd6;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] acc_mn(input logic [2:0] y);
    logic [6:0] r;
    case (y)
      3'd0: r = 7'd53;
      3'd1: r = 7'd58;
      3'd2: r = 7'd51;
      3'd3: r = 7'd56;
      3'd4: r = 7'd12;
      3'd5: r = 7'd11;
      3'd6: r = 7'd62;
      default: r = 7'd5;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] rot_mn(input logic [2:0] y);
    logic [6:0] r;
    case (y)
      3'd0: r = 7'd52;
      3'd1: r = 7'd57;
      3'd2: r = 7'd50;
      3'd3: r = 7'd55;
      3'd4: r = 7'd65;
      3'd5: r = 7'd66;
      3'd6: r = 7'd64;
      default: r = 7'd67;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] blk_mn(input logic [3:0] i);
    logic [6:0] r;
    case (i)
      4'd0: r = 7'd34;  4'd1: r = 7'd9;   4'd2: r = 7'd27;  4'd3: r = 7'd43;
      4'd4: r = 7'd32;  4'd5: r = 7'd7;   4'd6: r = 7'd25;  4'd7: r = 7'd42;
      4'd8: r = 7'd35;  4'd9: r = 7'd10;  4'd10: r = 7'd28; 4'd11: r = 7'd40;
      4'd12: r = 7'd33; 4'd13: r = 7'd8;  4'd14: r = 7'd26; default: r = 7'd39;
    endcase
    return r;
  endfunction

endpackage

>>> sv/z80_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// Z80 instruction decoder
// Three-stage pipelined decoder of one Z80 instruction per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries a four-byte window and its address; the block
// returns one result transaction per input, in order. The pipeline has three
// register stages (prefix classification, opcode table, and operand resolution
// into the output register), so a result is presented after its input has
// passed through all three, and a new window is taken every cycle while the
// output side is ready. A stall holds the whole pipeline; items in flight are
// kept, not dropped.
module z80_instruction_decoder_top import z80id_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pc[15:0], byte0[23:16], byte1[31:24], byte2[39:32], byte3[47:40]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // length[2:0], mnemonic_code[9:3], index_sel[11:10], dest_mode[16:12],
  // source_mode[21:17], dst_value[37:22], src_value[53:38], opcode[61:54],
  // zero fill [63:62]
  output logic [63:0] m_tdata
);

  pfx_t        pfx_c, pfx;
  tbl_t        tbl;
  decoded_t    dec_c;
  logic [2:0]  len_c;
  logic [15:0] dv_c, sv_c;
  logic        v1, v2, adv;

  // The pipeline moves when the output register is free or being drained.
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  z80id_prefix u_prefix (
    .pc(s_tdata[15:0]), .b0(s_tdata[23:16]), .b1(s_tdata[31:24]),
    .b2(s_tdata[39:32]), .b3(s_tdata[47:40]), .pfx(pfx_c)
  );

  z80id_table u_table (.pfx(pfx), .d(dec_c));

  z80id_operand u_operand (
    .t(tbl), .length(len_c), .dst_value(dv_c), .src_value(sv_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pfx <= pfx_c;
      tbl.p <= pfx;
      tbl.d <= dec_c;
      m_tdata <= {2'b00, tbl.p.op, sv_c, dv_c, tbl.d.sm, tbl.d.dm,
                  (tbl.p.space == SPACE_ED) ? 2'd0 : tbl.p.sel, tbl.d.mn, len_c};
    end
  end

endmodule

>>> sv/z80id_prefix.sv
// ----------------------------------------------------------------------------
// Z80 decoder prefix stage
// Classifies the DD, FD, ED and CB prefixes and picks the opcode byte.
// ----------------------------------------------------------------------------
module z80id_prefix import z80id_pkg::*; (
  input  logic [PC_W-1:0] pc,
  input  logic [7:0]      b0,
  input  logic [7:0]      b1,
  input  logic [7:0]      b2,
  input  logic [7:0]      b3,
  output pfx_t            pfx
);

  always_comb begin
    pfx.pc = pc; pfx.b0 = b0; pfx.b1 = b1; pfx.b2 = b2; pfx.b3 = b3;
    pfx.sel = 2'd0;
    pfx.space = SPACE_MAIN;
    pfx.op = b0;
    if (b0 == OP_ED) begin
      pfx.space = SPACE_ED;
      pfx.op = b1;
    end else if (b0 == OP_DD || b0 == OP_FD) begin
      pfx.sel = (b0 == OP_DD) ? 2'd1 : 2'd2;
      if (b1 == OP_CB) begin
        pfx.space = SPACE_CB;
        pfx.op = b3;
      end else begin
        pfx.op = b1;
      end
    end else if (b0 == OP_CB) begin
      pfx.space = SPACE_CB;
      pfx.op = b1;
    end
  end

endmodule

>>> sv/z80id_table.sv
// ----------------------------------------------------------------------------
// Z80 decoder table stage
// Maps the opcode in its table space to mnemonic and addressing modes.
// ----------------------------------------------------------------------------
module z80id_table import z80id_pkg::*; (
  input  pfx_t     pfx,
  output decoded_t d
);

  logic [7:0] op;
  logic [1:0] x;
  logic [2:0] y, z;
  logic       q, idx;

  assign op = pfx.op;
  assign x = op[7:6];
  assign y = op[5:3];
  assign z = op[2:0];
  assign q = op[3];
  assign idx = (pfx.sel != 2'd0);

  always_comb begin
    d = mk(MN_NOP, MD_IMPL, MD_IMPL);
    case (pfx.space)
      SPACE_CB: begin
        case (x)
          2'd0: d = mk(rot_mn(y), MD_RLOX, (idx && z != 3'd6) ? MD_XYD : MD_IMPL);
          2'd1: d = mk(MN_BIT, MD_BITN, idx ? MD_XYD : MD_RLO);
          2'd2: d = idx ? mk(MN_RES, MD_BITR, MD_XYD) : mk(MN_RES, MD_BITN, MD_RLO);
          default: d = idx ? mk(MN_SET, MD_BITR, MD_XYD) : mk(MN_SET, MD_BITN, MD_RLO);
        endcase
      end
      SPACE_ED: begin
        if (x == 2'd1) begin
          case (z)
            3'd0: d = (y == 3'd6) ? mk(MN_IN, MD_PORTC, MD_IMPL)
                                  : mk(MN_IN, MD_RMID, MD_PORTC);
            3'd1: d = (y == 3'd6) ? mk(MN_OUT, MD_PORTC, MD_ZERO)
                                  : mk(MN_OUT, MD_PORTC, MD_RMID);
            3'd2: d = mk(q ? MN_ADC : MN_SBC, MD_HL, MD_PAIR);
            3'd3: d = q ? mk(MN_LD, MD_PAIR, MD_ABS16) : mk(MN_LD, MD_ABS16, MD_PAIR);
            3'd4: d = mk(MN_NEG, MD_IMPL, MD_IMPL);
            3'd5: d = mk((y == 3'd1) ? MN_RETI : MN_RETN, MD_IMPL, MD_IMPL);
            3'd6: begin
              if (y == 3'd2 || y == 3'd6) d = mk(MN_IM1, MD_IMPL, MD_IMPL);
              else if (y == 3'd3 || y == 3'd7) d = mk(MN_IM2, MD_IMPL, MD_IMPL);
              else d = mk(MN_IM0, MD_IMPL, MD_IMPL);
            end
            default: begin
              case (y)
                3'd0: d = mk(MN_LD, MD_IREG, MD_A);
                3'd1: d = mk(MN_LD, MD_RREG, MD_A);
                3'd2: d = mk(MN_LD, MD_A, MD_IREG);
                3'd3: d = mk(MN_LD, MD_A, MD_RREG);
                3'd4: d = mk(MN_RRD, MD_IMPL, MD_IMPL);
                3'd5: d = mk(MN_RLD, MD_IMPL, MD_IMPL);
                default: d = mk(MN_NOP, MD_IMPL, MD_IMPL);
              endcase
            end
          endcase
        end else if (op[7:5] == 3'b101 && !z[2]) begin
          d = mk(blk_mn({y[1:0], z[1:0]}), MD_IMPL, MD_IMPL);
        end
      end
      default: begin
        case (x)
          2'd1: begin
            if (op == 8'h76) d = mk(MN_HALT, MD_IMPL, MD_IMPL);
            else d = mk(MN_LD, (z == 3'd6) ? MD_RMIDX : MD_RMID,
                        (y == 3'd6) ? MD_RLOX : MD_RLO);
          end
          2'd2: begin
            if (y == 3'd0 || y == 3'd1 || y == 3'd3) d = mk(alu_mn(y), MD_A, MD_RLO);
            else d = mk(alu_mn(y), MD_RLO, MD_IMPL);
          end
          2'd0: begin
            case (z)
              3'd0: begin
                case (y)
                  3'd0: d = mk(MN_NOP, MD_IMPL, MD_IMPL);
                  3'd1: d = mk(MN_EX, MD_AFAF, MD_IMPL);
                  3'd2: d = mk(MN_DJNZ, MD_REL, MD_IMPL);
                  3'd3: d = mk(MN_JR, MD_REL, MD_IMPL);
                  default: d = mk(MN_JR, MD_CC2, MD_REL);
                endcase
              end
              3'd1: d = q ? mk(MN_ADD, MD_HL, MD_PAIR) : mk(MN_LD, MD_PAIR, MD_IMM16);
              3'd2: begin
                case (y)
                  3'd0: d = mk(MN_LD, MD_BCI, MD_A);
                  3'd1: d = mk(MN_LD, MD_A, MD_BCI);
                  3'd2: d = mk(MN_LD, MD_DEI, MD_A);
                  3'd3: d = mk(MN_LD, MD_A, MD_DEI);
                  3'd4: d = mk(MN_LD, MD_ABS16, MD_HL);
                  3'd5: d = mk(MN_LD, MD_HL, MD_ABS16);
                  3'd6: d = mk(MN_LD, MD_ABS16, MD_A);
                  default: d = mk(MN_LD, MD_A, MD_ABS16);
                endcase
              end
              3'd3: d = mk(q ? MN_DEC : MN_INC, MD_PAIR, MD_IMPL);
              3'd4: d = mk(MN_INC, MD_RMID, MD_IMPL);
              3'd5: d = mk(MN_DEC, MD_RMID, MD_IMPL);
              3'd6: d = mk(MN_LD, MD_RMID, MD_IMM8);
              default: d = mk(acc_mn(y), MD_IMPL, MD_IMPL);
            endcase
          end
          default: begin
            case (z)
              3'd0: d = mk(MN_RET, MD_CC, MD_IMPL);
              3'd1: begin
                if (!q) d = mk(MN_POP, MD_PAIRAF, MD_IMPL);
                else if (y == 3'd1) d = mk(MN_RET, MD_IMPL, MD_IMPL);
                else if (y == 3'd3) d = mk(MN_EXX, MD_IMPL, MD_IMPL);
                else if (y == 3'd5) d = mk(MN_JP, MD_HLI, MD_IMPL);
                else d = mk(MN_LD, MD_SP, MD_HL);
              end
              3'd2: d = mk(MN_JP, MD_CC, MD_IMM16);
              3'd3: begin
                case (y)
                  3'd0: d = mk(MN_JP, MD_IMM16, MD_IMPL);
                  3'd1: d = mk(MN_ILLEGAL, MD_IMPL, MD_IMPL);
                  3'd2: d = mk(MN_OUT, MD_ABS8, MD_A);
                  3'd3: d = mk(MN_IN, MD_A, MD_ABS8);
                  3'd4: d = mk(MN_EX, MD_SPI, MD_HL);
                  3'd5: d = mk(MN_EX, MD_DEHL, MD_IMPL);
                  3'd6: d = mk(MN_DI, MD_IMPL, MD_IMPL);
                  default: d = mk(MN_EI, MD_IMPL, MD_IMPL);
                endcase
              end
              3'd4: d = mk(MN_CALL, MD_CC, MD_IMM16);
              3'd5: begin
                if (!q) d = mk(MN_PUSH, MD_PAIRAF, MD_IMPL);
                else if (y == 3'd1) d = mk(MN_CALL, MD_IMM16, MD_IMPL);
                else d = mk(MN_ILLEGAL, MD_IMPL, MD_IMPL);
              end
              3'd6: begin
                if (y == 3'd0 || y == 3'd1 || y == 3'd3) d = mk(alu_mn(y), MD_A, MD_IMM8);
                else d = mk(alu_mn(y), MD_IMM8, MD_IMPL);
              end
              default: d = mk(MN_RST, MD_RSTV, MD_IMPL);
            endcase
          end
        endcase
      end
    endcase
  end

endmodule

>>> sv/z80id_operand.sv
// ----------------------------------------------------------------------------
// Z80 decoder operand stage
// Resolves operand values from the window and computes the length.
// ----------------------------------------------------------------------------
module z80id_operand import z80id_pkg::*; (
  input  tbl_t            t,
  output logic [2:0]      length,
  output logic [15:0]     dst_value,
  output logic [15:0]     src_value
);

  logic [2:0] pos0, pos1, pos2;
  logic [2:0] dadv, sadv;
  logic       idx;

  assign idx = (t.p.sel != 2'd0) && (t.p.space != SPACE_ED);

  function automatic logic [7:0] fetch(input tbl_t tt, input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0: r = tt.p.b0;
      3'd1: r = tt.p.b1;
      3'd2: r = tt.p.b2;
      3'd3: r = tt.p.b3;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Returns the value and the number of window bytes the operand consumes.
  function automatic logic [18:0] opval(input tbl_t tt, input logic [4:0] mode,
                                        input logic [2:0] pos, input logic ix);
    logic [15:0] v;
    logic [2:0]  adv;
    logic [7:0]  r, op;
    logic [2:0]  reg_n;
    op = tt.p.op;
    v = 16'd0;
    adv = 3'd0;
    r = fetch(tt, pos);
    reg_n = (mode == MD_RLO || mode == MD_RLOX) ? op[2:0] : op[5:3];
    case (mode)
      MD_IMM8, MD_ABS8, MD_XYD: begin
        v = {8'd0, r}; adv = 3'd1;
      end
      MD_IMM16, MD_ABS16: begin
        v = {fetch(tt, pos + 3'd1), r}; adv = 3'd2;
      end
      MD_REL: begin
        v = tt.p.pc + {13'd0, pos} + 16'd1 + {{8{r[7]}}, r}; adv = 3'd1;
      end
      MD_RLO, MD_RLOX, MD_RMID, MD_RMIDX: begin
        if (reg_n == 3'd6 && ix) begin
          v = {8'd0, r}; adv = 3'd1;
        end else begin
          v = {13'd0, reg_n};
        end
      end
      MD_PAIR, MD_PAIRAF: v = {14'd0, op[5:4]};
      MD_CC, MD_BITN, MD_BITR: v = {13'd0, op[5:3]};
      MD_CC2: v = {14'd0, op[4:3]};
      MD_RSTV: v = {8'd0, op & 8'h38};
      default: v = 16'd0;
    endcase
    return {adv, v};
  endfunction

  always_comb begin
    case (t.p.space)
      SPACE_ED: pos0 = 3'd2;
      SPACE_CB: pos0 = idx ? 3'd2 : 3'd2;
      default: pos0 = idx ? 3'd2 : 3'd1;
    endcase
    {dadv, dst_value} = opval(t, t.d.dm, pos0, idx);
    pos1 = pos0 + dadv;
    {sadv, src_value} = opval(t, t.d.sm, pos1, idx);
    pos2 = pos1 + sadv;
    if (t.p.space == SPACE_CB) length = idx ? 3'd4 : 3'd2;
    else length = pos2;
  end

endmodule

>>> sv/z80id_checker.sv
// ----------------------------------------------------------------------------
// Z80 decoder port checker
// Checks result transactions seen on the ports of the decoder.
// ----------------------------------------------------------------------------
module z80id_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd0 && m_tdata[2:0] <= 3'd4))
    else $error("length out of range");

  a_mn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:3] <= 7'd70 && m_tdata[11:10] != 2'd3))
    else $error("mnemonic or index out of range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind z80_instruction_decoder_top z80id_port_checker u_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> tb/z80id_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Z80 decoder result checker
// Watches both stream channels, decodes every accepted window on its own and
// compares each result transaction field by field with the oldest decode.
// ----------------------------------------------------------------------------
module z80id_checker import z80id_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] src_value;
    logic [15:0] dst_value;
    logic [4:0]  source_mode;
    logic [4:0]  dest_mode;
    logic [1:0]  index_sel;
    logic [6:0]  mnemonic_code;
    logic [2:0]  length;
  } result_t;

  result_t decoded_q[$];

  function automatic decoded_t main_entry(input logic [7:0] op);
    logic [1:0] x;
    logic [2:0] y, z;
    x = op[7:6]; y = op[5:3]; z = op[2:0];
    if (x == 2'd1) begin
      if (op == 8'h76) return mk(MN_HALT, MD_IMPL, MD_IMPL);
      return mk(MN_LD, (z == 3'd6) ? MD_RMIDX : MD_RMID, (y == 3'd6) ? MD_RLOX : MD_RLO);
    end
    if (x == 2'd2) begin
      if (y == 3'd0 || y == 3'd1 || y == 3'd3) return mk(alu_mn(y), MD_A, MD_RLO);
      return mk(alu_mn(y), MD_RLO, MD_IMPL);
    end
    if (x == 2'd0) begin
      case (z)
        3'd0: begin
          if (y == 3'd0) return mk(MN_NOP, MD_IMPL, MD_IMPL);
          if (y == 3'd1) return mk(MN_EX, MD_AFAF, MD_IMPL);
          if (y == 3'd2) return mk(MN_DJNZ, MD_REL, MD_IMPL);
          if (y == 3'd3) return mk(MN_JR, MD_REL, MD_IMPL);
          return mk(MN_JR, MD_CC2, MD_REL);
        end
        3'd1: return y[0] ? mk(MN_ADD, MD_HL, MD_PAIR) : mk(MN_LD, MD_PAIR, MD_IMM16);
        3'd2: begin
          case (y)
            3'd0: return mk(MN_LD, MD_BCI, MD_A);
            3'd1: return mk(MN_LD, MD_A, MD_BCI);
            3'd2: return mk(MN_LD, MD_DEI, MD_A);
            3'd3: return mk(MN_LD, MD_A, MD_DEI);
            3'd4: return mk(MN_LD, MD_ABS16, MD_HL);
            3'd5: return mk(MN_LD, MD_HL, MD_ABS16);
            3'd6: return mk(MN_LD, MD_ABS16, MD_A);
            default: return mk(MN_LD, MD_A, MD_ABS16);
          endcase
        end
        3'd3: return mk(y[0] ? MN_DEC : MN_INC, MD_PAIR, MD_IMPL);
        3'd4: return mk(MN_INC, MD_RMID, MD_IMPL);
        3'd5: return mk(MN_DEC, MD_RMID, MD_IMPL);
        3'd6: return mk(MN_LD, MD_RMID, MD_IMM8);
        default: return mk(acc_mn(y), MD_IMPL, MD_IMPL);
      endcase
    end
    case (z)
      3'd0: return mk(MN_RET, MD_CC, MD_IMPL);
      3'd1: begin
        if (!y[0]) return mk(MN_POP, MD_PAIRAF, MD_IMPL);
        if (y == 3'd1) return mk(MN_RET, MD_IMPL, MD_IMPL);
        if (y == 3'd3) return mk(MN_EXX, MD_IMPL, MD_IMPL);
        if (y == 3'd5) return mk(MN_JP, MD_HLI, MD_IMPL);
        return mk(MN_LD, MD_SP, MD_HL);
      end
      3'd2: return mk(MN_JP, MD_CC, MD_IMM16);
      3'd3: begin
        case (y)
          3'd0: return mk(MN_JP, MD_IMM16, MD_IMPL);
          3'd1: return mk(MN_ILLEGAL, MD_IMPL, MD_IMPL);
          3'd2: return mk(MN_OUT, MD_ABS8, MD_A);
          3'd3: return mk(MN_IN, MD_A, MD_ABS8);
          3'd4: return mk(MN_EX, MD_SPI, MD_HL);
          3'd5: return mk(MN_EX, MD_DEHL, MD_IMPL);
          3'd6: return mk(MN_DI, MD_IMPL, MD_IMPL);
          default: return mk(MN_EI, MD_IMPL, MD_IMPL);
        endcase
      end
      3'd4: return mk(MN_CALL, MD_CC, MD_IMM16);
      3'd5: begin
        if (!y[0]) return mk(MN_PUSH, MD_PAIRAF, MD_IMPL);
        if (y == 3'd1) return mk(MN_CALL, MD_IMM16, MD_IMPL);
        return mk(MN_ILLEGAL, MD_IMPL, MD_IMPL);
      end
      3'd6: begin
        if (y == 3'd0 || y == 3'd1 || y == 3'd3) return mk(alu_mn(y), MD_A, MD_IMM8);
        return mk(alu_mn(y), MD_IMM8, MD_IMPL);
      end
      default: return mk(MN_RST, MD_RSTV, MD_IMPL);
    endcase
  endfunction

  function automatic decoded_t bitop_entry(input logic [7:0] op, input logic idx);
    case (op[7:6])
      2'd0: return mk(rot_mn(op[5:3]), MD_RLOX,
                      (idx && op[2:0] != 3'd6) ? MD_XYD : MD_IMPL);
      2'd1: return mk(MN_BIT, MD_BITN, idx ? MD_XYD : MD_RLO);
      2'd2: return idx ? mk(MN_RES, MD_BITR, MD_XYD) : mk(MN_RES, MD_BITN, MD_RLO);
      default: return idx ? mk(MN_SET, MD_BITR, MD_XYD) : mk(MN_SET, MD_BITN, MD_RLO);
    endcase
  endfunction

  function automatic decoded_t ext_entry(input logic [7:0] op);
    logic [2:0] y, z;
    y = op[5:3]; z = op[2:0];
    if (op[7:6] == 2'd1) begin
      case (z)
        3'd0: return (y == 3'd6) ? mk(MN_IN, MD_PORTC, MD_IMPL) : mk(MN_IN, MD_RMID, MD_PORTC);
        3'd1: return (y == 3'd6) ? mk(MN_OUT, MD_PORTC, MD_ZERO)
                                 : mk(MN_OUT, MD_PORTC, MD_RMID);
        3'd2: return mk(y[0] ? MN_ADC : MN_SBC, MD_HL, MD_PAIR);
        3'd3: return y[0] ? mk(MN_LD, MD_PAIR, MD_ABS16) : mk(MN_LD, MD_ABS16, MD_PAIR);
        3'd4: return mk(MN_NEG, MD_IMPL, MD_IMPL);
        3'd5: return mk((y == 3'd1) ? MN_RETI : MN_RETN, MD_IMPL, MD_IMPL);
        3'd6: begin
          if (y == 3'd2 || y == 3'd6) return mk(MN_IM1, MD_IMPL, MD_IMPL);
          if (y == 3'd3 || y == 3'd7) return mk(MN_IM2, MD_IMPL, MD_IMPL);
          return mk(MN_IM0, MD_IMPL, MD_IMPL);
        end
        default: begin
          case (y)
            3'd0: return mk(MN_LD, MD_IREG, MD_A);
            3'd1: return mk(MN_LD, MD_RREG, MD_A);
            3'd2: return mk(MN_LD, MD_A, MD_IREG);
            3'd3: return mk(MN_LD, MD_A, MD_RREG);
            3'd4: return mk(MN_RRD, MD_IMPL, MD_IMPL);
            3'd5: return mk(MN_RLD, MD_IMPL, MD_IMPL);
            default: return mk(MN_NOP, MD_IMPL, MD_IMPL);
          endcase
        end
      endcase
    end
    if (op >= 8'ha0 && op <= 8'hbf && z < 3'd4) return mk(blk_mn({y[1:0], z[1:0]}), MD_IMPL, MD_IMPL);
    return mk(MN_NOP, MD_IMPL, MD_IMPL);
  endfunction

  function automatic logic [7:0] window_byte(input logic [31:0] w, input int k);
    return (k < 4) ? w[8*k +: 8] : 8'h00;
  endfunction

  // Resolves one operand and advances the byte cursor past what it consumed.
  function automatic logic [15:0] operand(input logic [4:0] mode, inout int pos,
                                          input logic [7:0] op, input logic idx,
                                          input logic [31:0] w, input logic [15:0] pc);
    logic [15:0] v;
    logic [7:0] r;
    v = 16'd0;
    case (mode)
      MD_IMM8, MD_ABS8, MD_XYD: begin
        v = {8'd0, window_byte(w, pos)}; pos++;
      end
      MD_IMM16, MD_ABS16: begin
        v = {window_byte(w, pos + 1), window_byte(w, pos)}; pos += 2;
      end
      MD_REL: begin
        r = window_byte(w, pos);
        v = pc + 16'(pos) + 16'd1 + {{8{r[7]}}, r};
        pos++;
      end
      MD_RLO, MD_RLOX, MD_RMID, MD_RMIDX: begin
        r = (mode == MD_RLO || mode == MD_RLOX) ? {5'd0, op[2:0]} : {5'd0, op[5:3]};
        if (r == 8'd6 && idx) begin
          v = {8'd0, window_byte(w, pos)}; pos++;
        end else v = {8'd0, r};
      end
      MD_PAIR, MD_PAIRAF: v = {14'd0, op[5:4]};
      MD_CC, MD_BITN, MD_BITR: v = {13'd0, op[5:3]};
      MD_CC2: v = {14'd0, op[4:3]};
      MD_RSTV: v = {8'd0, op & 8'h38};
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic result_t decode_window(input logic [47:0] d);
    result_t res;
    decoded_t e;
    logic [15:0] pc;
    logic [31:0] w;
    logic [7:0] op;
    logic [1:0] sel;
    logic idx;
    int base, pos, len;
    pc = d[15:0]; w = d[47:16];
    sel = 2'd0; base = 0;
    if (w[7:0] == OP_ED) begin
      op = w[15:8]; e = ext_entry(op); idx = 1'b0; pos = 2;
      res.dst_value = operand(e.dm, pos, op, idx, w, pc);
      res.src_value = operand(e.sm, pos, op, idx, w, pc);
      len = pos;
    end else begin
      if (w[7:0] == OP_DD) begin
        sel = 2'd1; base = 1;
      end else if (w[7:0] == OP_FD) begin
        sel = 2'd2; base = 1;
      end
      idx = (sel != 2'd0);
      op = window_byte(w, base);
      if (op == OP_CB) begin
        if (idx) begin
          op = window_byte(w, base + 2); pos = base + 1; len = base + 3;
        end else begin
          op = window_byte(w, base + 1); pos = base + 2; len = base + 2;
        end
        e = bitop_entry(op, idx);
        res.dst_value = operand(e.dm, pos, op, idx, w, pc);
        res.src_value = operand(e.sm, pos, op, idx, w, pc);
      end else begin
        // An index prefix followed by DD, ED or FD lands on an illegal slot here.
        if (idx && (op == OP_DD || op == OP_ED || op == OP_FD))
          e = mk(MN_ILLEGAL, MD_IMPL, MD_IMPL);
        else
          e = main_entry(op);
        pos = base + 1;
        res.dst_value = operand(e.dm, pos, op, idx, w, pc);
        res.src_value = operand(e.sm, pos, op, idx, w, pc);
        len = pos;
      end
    end
    res.length = 3'(len);
    res.mnemonic_code = e.mn;
    res.index_sel = sel;
    res.dest_mode = e.dm;
    res.source_mode = e.sm;
    res.opcode = op;
    return res;
  endfunction

  assign pending_count = decoded_q.size();

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) decoded_q.push_back(decode_window(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[61:0];
        if (decoded_q.size() == 0) begin
          $error("result transaction with no input pending: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = decoded_q.pop_front();
          if (got != want || m_tdata[63:62] != 2'b00) begin
            fail_count <= fail_count + 1;
            if (got.length != want.length)
              $error("length: expected %0d, actual %0d", want.length, got.length);
            if (got.mnemonic_code != want.mnemonic_code)
              $error("mnemonic_code: expected %0d, actual %0d",
                     want.mnemonic_code, got.mnemonic_code);
            if (got.index_sel != want.index_sel)
              $error("index_sel: expected %0d, actual %0d", want.index_sel, got.index_sel);
            if (got.dest_mode != want.dest_mode)
              $error("dest_mode: expected %0d, actual %0d", want.dest_mode, got.dest_mode);
            if (got.source_mode != want.source_mode)
              $error("source_mode: expected %0d, actual %0d",
                     want.source_mode, got.source_mode);
            if (got.dst_value != want.dst_value)
              $error("dst_value: expected %h, actual %h", want.dst_value, got.dst_value);
            if (got.src_value != want.src_value)
              $error("src_value: expected %h, actual %h", want.src_value, got.src_value);
            if (got.opcode != want.opcode)
              $error("opcode: expected %h, actual %h", want.opcode, got.opcode);
            if (m_tdata[63:62] != 2'b00)
              $error("zero fill: expected 0, actual %0d", m_tdata[63:62]);
          end
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Z80 instruction decoder testbench
// Sends directed and random instruction windows under several idling phases
// and leaves all checking to the result checker.
// ----------------------------------------------------------------------------
module tb import z80id_pkg::*; ;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  always #10 clk = ~clk;

  z80_instruction_decoder_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  z80id_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("z80_instruction_decoder_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Presents one window and holds it until the decoder takes it. The valid
  // line stays high on return, so back-to-back windows leave no gap; the
  // caller drops it when the stream pauses.
  task automatic send_window(input logic [15:0] pc, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b3, b2, b1, b0, pc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_prefix();
    case ($urandom_range(5))
      0: return OP_DD;
      1: return OP_FD;
      2: return OP_ED;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] p, q;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes, prefix chains, indexed bit ops, relative wraparound and ED forms.
    send_window(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_window(16'hffff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_window(16'hfffe, 8'h18, 8'h7f, 8'h00, 8'h00);
    send_window(16'h0000, 8'h10, 8'h80, 8'h00, 8'h00);
    send_window(16'h1234, 8'hdd, 8'hdd, 8'h00, 8'h00);
    send_window(16'h1234, 8'hfd, 8'hed, 8'h00, 8'h00);
    send_window(16'h1234, 8'hdd, 8'hfd, 8'h00, 8'h00);
    send_window(16'h0100, 8'hdd, 8'hcb, 8'h80, 8'h46);
    send_window(16'h0100, 8'hfd, 8'hcb, 8'h7f, 8'hc6);
    send_window(16'h0100, 8'hfd, 8'hcb, 8'h05, 8'h01);
    send_window(16'h0100, 8'hcb, 8'h3e, 8'h00, 8'h00);
    send_window(16'h0100, 8'hdd, 8'h36, 8'hfe, 8'hab);
    send_window(16'h0100, 8'hfd, 8'h66, 8'h12, 8'h00);
    send_window(16'h0100, 8'hdd, 8'h21, 8'h34, 8'h12);
    send_window(16'h0100, 8'hed, 8'h70, 8'h00, 8'h00);
    send_window(16'h0100, 8'hed, 8'h71, 8'h00, 8'h00);
    send_window(16'h0100, 8'hed, 8'h57, 8'h00, 8'h00);
    send_window(16'h0100, 8'hed, 8'h4f, 8'h00, 8'h00);
    send_window(16'h0100, 8'hed, 8'h43, 8'hcd, 8'hab);
    send_window(16'h0100, 8'hed, 8'hb0, 8'h00, 8'h00);
    send_window(16'h0100, 8'hed, 8'h00, 8'h00, 8'h00);
    send_window(16'h0100, 8'hd3, 8'hfe, 8'h00, 8'h00);
    send_window(16'h0100, 8'hcd, 8'h00, 8'h80, 8'h00);
    send_window(16'h0100, 8'hff, 8'h00, 8'h00, 8'h00);
    s_tvalid <= 1'b0;

    // Let every result drain before the random phases start.
    wait (pending_count == 0);
    @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < 320; n++) begin
        p = any_prefix();
        q = ($urandom_range(3) == 0) ? OP_CB : 8'($urandom);
        send_window(16'($urandom), p, q, 8'($urandom), 8'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("z80_instruction_decoder_top verification clean");
    else
      $display("z80_instruction_decoder_top verification failed");
    $finish;
  end

endmodule

>>> z80_instruction_decoder_top.f
sv/z80id_pkg.sv
sv/z80id_prefix.sv
sv/z80id_table.sv
sv/z80id_operand.sv
sv/z80_instruction_decoder_top.sv
sv/z80id_checker.sv
tb/z80id_checker.sv
tb/tb.sv
